FILE: design/psim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psim_pkg: shared types and constants of the stride index map
// Register map, configuration bundle and fixed field widths.
// ----------------------------------------------------------------------------
package psim_pkg;

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int STRIDE_W = 32;
  localparam int DIMS_W   = 3;
  localparam int PERM_W   = 8;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd1;
  localparam logic [PERM_W-1:0] PERM_RESET = 8'd228;

  // Register index, byte address / 4
  typedef enum logic [2:0] {
    REG_ACTIVE_DIMS  = 3'd0,
    REG_OUT_STRIDE_1 = 3'd1,
    REG_OUT_STRIDE_2 = 3'd2,
    REG_OUT_STRIDE_3 = 3'd3,
    REG_IN_STRIDE_1  = 3'd4,
    REG_IN_STRIDE_2  = 3'd5,
    REG_IN_STRIDE_3  = 3'd6,
    REG_DIM_PERM     = 3'd7
  } reg_idx_t;

  // Configuration bundle; entry 0 of each stride array is fixed at 1
  typedef struct packed {
    logic [DIMS_W-1:0]              active_dims;
    logic [3:0][STRIDE_W-1:0]       out_stride;
    logic [3:0][STRIDE_W-1:0]       in_stride;
    logic [PERM_W-1:0]              dim_permutation;
  } cfg_t;

endpackage

FILE: design/permuted_stride_index_map_unit.sv
`timescale 1ns / 1ps
// Pipeline: one bit-per-stage divider pipeline for each dimension above 0,
//   followed by three multiply/add stages.
// Throughput: one transaction per cycle; the whole pipeline stalls together.
// Reset: synchronous; clears all stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// permuted_stride_index_map_unit: transpose address generator
// Maps a linear output index to the linear input index of a permuted tensor.
// ----------------------------------------------------------------------------
module permuted_stride_index_map_unit #(
  parameter int MAX_DIMS   = 4,
  parameter int INDEX_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psim_pkg::ADDR_W-1:0]  paddr,
  input  logic [psim_pkg::DATA_W-1:0]  pwdata,
  output logic [psim_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  out_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [31:0]                  in_index,
  output logic                         index_overflow
);

  localparam int IB = INDEX_BITS;
  localparam int ND = MAX_DIMS - 1;
  localparam int SW = MAX_DIMS * IB;
  localparam logic [2:0] MAXD = 3'(MAX_DIMS);

  psim_pkg::cfg_t cfg;
  logic           en;
  logic [2:0]     dims_eff;

  logic                         vld  [ND+1];
  logic [IB-1:0]                rem  [ND+1];
  logic [MAX_DIMS-1:0][IB-1:0]  qv   [ND+1];
  logic [MAX_DIMS-1:0][IB-1:0]  coord;
  logic [MAX_DIMS-1:0][31:0]    istr;
  logic [IB-1:0]                idx;

  psim_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // whole pipeline advances unless the output register is held
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  // clamp dimension count to 1..MAX_DIMS
  always_comb begin
    if (cfg.active_dims == 3'd0) dims_eff = 3'd1;
    else if (cfg.active_dims > MAXD) dims_eff = MAXD;
    else dims_eff = cfg.active_dims;
  end

  assign vld[0] = in_valid;
  assign rem[0] = out_index[IB-1:0];
  assign qv[0]  = '0;

  // one divider per dimension above 0, highest first
  for (genvar j = 0; j < ND; j++) begin : g_dim
    localparam int D = MAX_DIMS - 1 - j;
    logic [32:0]   dvs;
    logic [31:0]   os;
    logic          dv;
    logic [IB-1:0] q, r;
    logic [SW-1:0] sd;
    logic [MAX_DIMS-1:0][IB-1:0] qn;

    // inactive dimension divides by 2^32: quotient 0, remainder kept
    assign os  = (cfg.out_stride[D] == 32'd0) ? 32'd1 : cfg.out_stride[D];
    assign dvs = (3'(D) < dims_eff) ? {1'b0, os} : 33'h1_0000_0000;

    psim_div #(.IB(IB), .SIDE_W(SW)) u_div (
      .clk, .rst, .en,
      .in_valid (vld[j]),
      .dividend (rem[j]),
      .divisor  (dvs),
      .side_in  (qv[j]),
      .out_valid(dv),
      .quot     (q),
      .rem      (r),
      .side_out (sd)
    );

    always_comb begin
      qn    = sd;
      qn[D] = q;
    end
    assign qv[j+1]  = qn;
    assign vld[j+1] = dv;
    assign rem[j+1] = r;
  end

  // dimension 0 takes the leftover remainder
  always_comb begin
    coord    = qv[ND];
    coord[0] = rem[ND];
  end

  // input stride of the source dimension for each output dimension
  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_istr
    assign istr[k] = cfg.in_stride[cfg.dim_permutation[2*k +: 2]];
  end

  psim_acc #(.MD(MAX_DIMS), .IB(IB)) u_acc (
    .clk, .rst, .en,
    .in_valid (vld[ND]),
    .coord    (coord),
    .stride   (istr),
    .out_valid(out_valid),
    .index    (idx),
    .ovf      (index_overflow)
  );

  assign in_index = 32'(idx);

endmodule

FILE: design/psim_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psim_regs: configuration register file
// APB-style write/read port holding dimension count, strides and permutation.
// ----------------------------------------------------------------------------
module psim_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psim_pkg::ADDR_W-1:0]  paddr,
  input  logic [psim_pkg::DATA_W-1:0]  pwdata,
  output logic [psim_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output psim_pkg::cfg_t               cfg
);

  logic [psim_pkg::DIMS_W-1:0]   active_dims;
  logic [3:1][psim_pkg::STRIDE_W-1:0] out_stride;
  logic [3:1][psim_pkg::STRIDE_W-1:0] in_stride;
  logic [psim_pkg::PERM_W-1:0]   dim_permutation;
  psim_pkg::reg_idx_t            idx;
  logic                          wr;

  assign pready = 1'b1;
  assign idx    = psim_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      active_dims     <= psim_pkg::DIMS_RESET;
      out_stride      <= {3{32'd1}};
      in_stride       <= {3{32'd1}};
      dim_permutation <= psim_pkg::PERM_RESET;
    end else if (wr) begin
      unique case (idx)
        psim_pkg::REG_ACTIVE_DIMS:  active_dims     <= pwdata[psim_pkg::DIMS_W-1:0];
        psim_pkg::REG_OUT_STRIDE_1: out_stride[1]   <= pwdata;
        psim_pkg::REG_OUT_STRIDE_2: out_stride[2]   <= pwdata;
        psim_pkg::REG_OUT_STRIDE_3: out_stride[3]   <= pwdata;
        psim_pkg::REG_IN_STRIDE_1:  in_stride[1]    <= pwdata;
        psim_pkg::REG_IN_STRIDE_2:  in_stride[2]    <= pwdata;
        psim_pkg::REG_IN_STRIDE_3:  in_stride[3]    <= pwdata;
        psim_pkg::REG_DIM_PERM:     dim_permutation <= pwdata[psim_pkg::PERM_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      psim_pkg::REG_ACTIVE_DIMS:  prdata = 32'(active_dims);
      psim_pkg::REG_OUT_STRIDE_1: prdata = out_stride[1];
      psim_pkg::REG_OUT_STRIDE_2: prdata = out_stride[2];
      psim_pkg::REG_OUT_STRIDE_3: prdata = out_stride[3];
      psim_pkg::REG_IN_STRIDE_1:  prdata = in_stride[1];
      psim_pkg::REG_IN_STRIDE_2:  prdata = in_stride[2];
      psim_pkg::REG_IN_STRIDE_3:  prdata = in_stride[3];
      psim_pkg::REG_DIM_PERM:     prdata = 32'(dim_permutation);
      default:                    prdata = '0;
    endcase
  end

  // dimension 0 has unit stride on both sides
  assign cfg.active_dims     = active_dims;
  assign cfg.out_stride      = {out_stride, 32'd1};
  assign cfg.in_stride       = {in_stride, 32'd1};
  assign cfg.dim_permutation = dim_permutation;

endmodule

FILE: design/psim_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psim_div: pipelined restoring divider
// One quotient bit per stage, IB stages; side data travels with each item.
// ----------------------------------------------------------------------------
module psim_div #(
  parameter int IB     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IB-1:0]     dividend,
  input  logic [32:0]       divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [IB-1:0]     quot,
  output logic [IB-1:0]     rem,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld [IB];
  logic [IB-1:0]     r   [IB];
  logic [IB-1:0]     qq  [IB];
  logic [IB-1:0]     dd  [IB];
  logic [SIDE_W-1:0] sd  [IB];

  for (genvar s = 0; s < IB; s++) begin : g_stage
    logic              p_v;
    logic [IB-1:0]     p_r, p_q, p_d;
    logic [SIDE_W-1:0] p_s;
    logic [IB:0]       trial;
    logic [33:0]       diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign p_v = in_valid;
      assign p_r = '0;
      assign p_q = '0;
      assign p_d = dividend;
      assign p_s = side_in;
    end else begin : g_next
      assign p_v = vld[s-1];
      assign p_r = r[s-1];
      assign p_q = qq[s-1];
      assign p_d = dd[s-1];
      assign p_s = sd[s-1];
    end

    // trial subtract of the next dividend bit
    assign trial = {p_r, p_d[IB-1-s]};
    assign diff  = {{(33-IB){1'b0}}, trial} - {1'b0, divisor};
    assign ge    = ~diff[33];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[s]  <= ge ? diff[IB-1:0] : trial[IB-1:0];
        qq[s] <= p_q | (IB'(ge) << (IB-1-s));
        dd[s] <= p_d;
        sd[s] <= p_s;
      end
    end
  end

  assign out_valid = vld[IB-1];
  assign quot      = qq[IB-1];
  assign rem       = r[IB-1];
  assign side_out  = sd[IB-1];

endmodule

FILE: design/psim_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psim_acc: weight-and-sum back end
// Multiplies each dimension coordinate by its input stride, then sums the
// terms in a two-level adder tree and flags any carry past the index width.
// ----------------------------------------------------------------------------
module psim_acc #(
  parameter int MD = 4,
  parameter int IB = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [MD-1:0][IB-1:0]    coord,
  input  logic [MD-1:0][31:0]      stride,
  output logic                     out_valid,
  output logic [IB-1:0]            index,
  output logic                     ovf
);

  localparam int PW = IB + 32;

  logic [PW-1:0] prod [4];
  logic [IB:0]   s01, s23;
  logic          ovf1;
  logic          v1, v2, v3;
  logic [IB-1:0] t   [4];
  logic [3:0]    hi;
  logic [IB+1:0] total;

  // stage 1: products
  for (genvar k = 0; k < 4; k++) begin : g_mul
    if (k < MD) begin : g_on
      always_ff @(posedge clk) begin
        if (en) prod[k] <= PW'(coord[k]) * PW'(stride[k]);
      end
    end else begin : g_off
      assign prod[k] = '0;
    end
    assign t[k]  = prod[k][IB-1:0];
    assign hi[k] = |prod[k][PW-1:IB];
  end

  // stage 2: pair sums and product overflow
  always_ff @(posedge clk) begin
    if (en) begin
      s01  <= {1'b0, t[0]} + {1'b0, t[1]};
      s23  <= {1'b0, t[2]} + {1'b0, t[3]};
      ovf1 <= |hi;
    end
  end

  // stage 3: final sum; any carry out means overflow
  assign total = {1'b0, s01} + {1'b0, s23};

  always_ff @(posedge clk) begin
    if (en) begin
      index <= total[IB-1:0];
      ovf   <= ovf1 | (|total[IB+1:IB]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the transpose address generator
// Predicts each input index from the configured strides and permutation,
// drives random traffic with stalls on both sides and checks every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY   = 99;
  localparam int WDOG_MAX  = 20000;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [psim_pkg::ADDR_W-1:0] paddr;
  logic [psim_pkg::DATA_W-1:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [31:0] out_index;
  logic        out_valid, out_ready;
  logic [31:0] in_index;
  logic        index_overflow;

  permuted_stride_index_map_unit uut (.*);

  // Predictor copy of the register file
  logic [2:0]  m_dims;
  logic [31:0] m_os [4];
  logic [31:0] m_is [4];
  logic [7:0]  m_perm;

  typedef struct packed {
    logic [31:0] idx;
    logic        ovf;
  } addr_res_t;

  addr_res_t addr_q[$];
  int   errors = 0, checked = 0, sent = 0;
  bit   idle_en = 1;
  bit   hold_rx = 0;
  int   wdog = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Walk dimensions from the top, dividing down and accumulating
  function automatic addr_res_t map_index(logic [31:0] oi);
    addr_res_t r;
    logic [63:0] rem, acc, os, is, q, prod;
    int dims;
    logic [1:0] src;
    rem  = {32'd0, oi};
    acc  = 0;
    r.ovf = 0;
    dims = m_dims;
    if (dims < 1) dims = 1;
    if (dims > 4) dims = 4;
    for (int i = dims - 1; i >= 0; i--) begin
      os  = (i == 0) ? 64'd1 : {32'd0, m_os[i]};
      src = m_perm[2*i +: 2];
      is  = (src == 0) ? 64'd1 : {32'd0, m_is[src]};
      if (os == 0) os = 1;
      q    = rem / os;
      rem  = rem - q * os;
      prod = q * is;
      if (prod[63:32] != 0) r.ovf = 1;
      acc = acc + {32'd0, prod[31:0]};
      if (acc[63:32] != 0) r.ovf = 1;
      acc = {32'd0, acc[31:0]};
    end
    r.idx = acc[31:0];
    return r;
  endfunction

  // APB write, setup then access; the bus is released by the caller
  task automatic reg_write(psim_pkg::reg_idx_t ri, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= psim_pkg::ADDR_W'(ri) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (ri)
      psim_pkg::REG_ACTIVE_DIMS:  m_dims = v[2:0];
      psim_pkg::REG_OUT_STRIDE_1: m_os[1] = v;
      psim_pkg::REG_OUT_STRIDE_2: m_os[2] = v;
      psim_pkg::REG_OUT_STRIDE_3: m_os[3] = v;
      psim_pkg::REG_IN_STRIDE_1:  m_is[1] = v;
      psim_pkg::REG_IN_STRIDE_2:  m_is[2] = v;
      psim_pkg::REG_IN_STRIDE_3:  m_is[3] = v;
      psim_pkg::REG_DIM_PERM:     m_perm = v[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [2:0] d, logic [31:0] o1, o2, o3, i1, i2, i3,
                           logic [7:0] p);
    reg_write(psim_pkg::REG_ACTIVE_DIMS, {29'd0, d});
    reg_write(psim_pkg::REG_OUT_STRIDE_1, o1);
    reg_write(psim_pkg::REG_OUT_STRIDE_2, o2);
    reg_write(psim_pkg::REG_OUT_STRIDE_3, o3);
    reg_write(psim_pkg::REG_IN_STRIDE_1, i1);
    reg_write(psim_pkg::REG_IN_STRIDE_2, i2);
    reg_write(psim_pkg::REG_IN_STRIDE_3, i3);
    reg_write(psim_pkg::REG_DIM_PERM, {24'd0, p});
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // Send one transaction; valid held until accepted, dropped only when idling
  task automatic send_index(logic [31:0] v);
    while (idle_en && $urandom_range(99) < 9) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid  <= 1;
    out_index <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    addr_q.insert(addr_q.size(), map_index(v));
    sent++;
  endtask

  // Drain: wait for queue empty then let the pipe settle
  task automatic drain();
    in_valid <= 0;
    while (addr_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_stride();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(2, 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_index();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Receiver side: random ready, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !hold_rx && !(idle_en && $urandom_range(99) < 9);
  end

  // Result checker
  always @(posedge clk) begin
    addr_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (addr_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result idx=%h ovf=%b", in_index, index_overflow);
      end else begin
        e = addr_q.pop_front();
        checked++;
        if (e.idx !== in_index || e.ovf !== index_overflow) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp idx=%h ovf=%b got idx=%h ovf=%b",
                     e.idx, e.ovf, in_index, index_overflow);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (psel && penable)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_index(32'd0);
    send_index(32'hFFFF_FFFF);
    send_index(32'd12345);
    drain();
  endtask

  task automatic test_directed();
    // identity 4-D, plain strides
    write_all(3'd4, 4, 16, 64, 4, 16, 64, 8'd228);
    send_index(32'd0); send_index(32'd63); send_index(32'hFFFF_FFFF);
    drain();
    // transpose with big input strides: overflow
    write_all(3'd4, 2, 6, 24, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1_0000, 8'h1B);
    send_index(32'hFFFF_FFFF); send_index(32'd23); send_index(32'd7);
    drain();
    // zero output stride, zero input stride, dims zero
    write_all(3'd0, 0, 0, 0, 0, 0, 0, 8'hFF);
    send_index(32'hDEAD_BEEF); send_index(32'd1);
    drain();
    // dims above the maximum, permutation pointing every dimension at dimension 0
    write_all(3'd7, 32'hFFFF_FFFF, 3, 0, 0, 5, 7, 8'h00);
    send_index(32'hFFFF_FFFF); send_index(32'd5); send_index(32'h8000_0000);
    drain();
    write_all(3'd2, 3, 1, 1, 9, 1, 1, 8'hE1);
    send_index(32'd8); send_index(32'hFFFF_FFFE);
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      write_all(3'($urandom_range(7)), rand_stride(), rand_stride(), rand_stride(),
                rand_stride(), rand_stride(), rand_stride(), 8'($urandom));
      idle_en = (ph != 3);
      for (int k = 0; k < 55; k++) send_index(rand_index());
      drain();
    end
    idle_en = 1;
  endtask

  // Receiver held off long enough to fill the pipe and stall the input
  task automatic test_backpressure();
    write_all(3'd3, 7, 50, 1000, 3, 33, 999, 8'h93);
    hold_rx = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_rx = 0;
      end
      for (int k = 0; k < 150; k++) send_index(rand_index());
    join
    drain();
  endtask

  initial begin
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; out_index = 0;
    m_dims = psim_pkg::DIMS_RESET; m_perm = psim_pkg::PERM_RESET;
    for (int i = 0; i < 4; i++) begin
      m_os[i] = 1; m_is[i] = 1;
    end
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    $display("sent %0d indices, checked %0d results over directed, stall and random phases",
             sent, checked);
    if (errors == 0 && addr_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
